// ===== src/swfd_pkg.sv =====
// Shared types and constants of the substring word filter with unique word table.
package swfd_pkg;

    typedef enum logic [1:0] {
        FUNC_CHAR    = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_RESTART = 2'd2
    } t_func;

    localparam int FUNC_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int RSLOT_W     = 4;
    localparam int RPOS_W      = 6;
    localparam int OSLOT_W     = 4;
    localparam int OCOUNT_W    = 5;
    localparam int OLEN_W      = 6;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PLEN_W      = 6;
    localparam int PAT_BITS    = 256;

    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LEN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHARS_A     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHARS_B     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHARS_C     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHARS_D     = 3'd4;

    localparam logic [1:0] END_LEN = 2'd3;

    function automatic logic [CHAR_W-1:0] end_char(input logic [1:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            2'd0:    c = 8'h66;
            2'd1:    c = 8'h69;
            2'd2:    c = 8'h6e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/swfd_in_if.sv =====
// Input request channel carrying one character or command.
interface swfd_in_if;
    logic                            valid;
    logic                            ready;
    logic [swfd_pkg::FUNC_W-1:0]     func;
    logic [swfd_pkg::CHAR_W-1:0]     char_in;
    logic                            word_end;
    logic [swfd_pkg::RSLOT_W-1:0]    read_slot;
    logic [swfd_pkg::RPOS_W-1:0]     read_pos;

    modport source (output valid, func, char_in, word_end, read_slot, read_pos, input ready);
    modport sink (input valid, func, char_in, word_end, read_slot, read_pos, output ready);
endinterface

// ===== src/swfd_out_if.sv =====
// Result channel carrying one word or read result.
interface swfd_out_if;
    logic                             valid;
    logic                             ready;
    logic                             word_matched;
    logic                             word_new;
    logic [swfd_pkg::OSLOT_W-1:0]     word_slot;
    logic [swfd_pkg::OCOUNT_W-1:0]    stored_count;
    logic                             intake_stopped;
    logic [swfd_pkg::CHAR_W-1:0]      read_char;
    logic [swfd_pkg::OLEN_W-1:0]      read_len;

    modport source (output valid, word_matched, word_new, word_slot, stored_count,
                    intake_stopped, read_char, read_len, input ready);
    modport sink (input valid, word_matched, word_new, word_slot, stored_count,
                  intake_stopped, read_char, read_len, output ready);
endinterface

// ===== src/swfd_cfg_if.sv =====
// Configuration write channel.
interface swfd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [swfd_pkg::CFG_ADDR_W-1:0]    addr;
    logic [swfd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== src/swfd_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module swfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/substring_word_filter_dedup_top.sv =====
// Top level of the substring word filter with unique word table.
// An accepted request is registered in the second stage; its result then moves into the output register.
// Throughput: one request per cycle, limited by the per-slot word banks read once a cycle.
// The input is stalled only while the output register holds a result the sink has not taken.
// Reset is synchronous, active low; it clears the table, the word in progress and the pattern.
// The word banks are not cleared; entries are only read below a written slot length.
module substring_word_filter_dedup_top #(
    parameter int SLOTS         = 16,
    parameter int WORD_CHARS    = 63,
    parameter int PATTERN_CHARS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swfd_in_if.sink    i_in,
    swfd_out_if.source o_out,
    swfd_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(WORD_CHARS);
    localparam int LW = $clog2(WORD_CHARS + 1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = PATTERN_CHARS;

    typedef struct packed {
        logic [1:0]                      func;
        logic [swfd_pkg::CHAR_W-1:0]     ch;
        logic                            wend;
        logic                            take;
        logic [AW-1:0]                   pos;
        logic [LW-1:0]                   len;
        logic                            found;
        logic [1:0]                      track;
        logic [swfd_pkg::RSLOT_W-1:0]    rslot;
        logic [swfd_pkg::RPOS_W-1:0]     rpos;
    } t_s1;

    logic [swfd_pkg::PLEN_W-1:0]   r_plen;
    logic [swfd_pkg::PAT_BITS-1:0] r_pat;

    logic [LW-1:0] r_len;
    logic [PW-1:0] r_mv;
    logic          r_found;
    logic [1:0]    r_track;

    logic r_s1_valid;
    t_s1  r_s1;
    t_s1  n_s1;
    logic n_s1_valid;

    logic [SLOTS-1:0] r_eq, n_eq;
    logic [LW-1:0]    r_slen [SLOTS];
    logic [LW-1:0]    n_slen [SLOTS];
    logic [CW-1:0]    r_count, n_count;
    logic             r_stopped, n_stopped;

    logic                             r_ovalid;
    logic                             r_omatched, r_onew, r_ostop;
    logic [swfd_pkg::OSLOT_W-1:0]     r_oslot;
    logic [swfd_pkg::OCOUNT_W-1:0]    r_ocount;
    logic [swfd_pkg::CHAR_W-1:0]      r_ochar;
    logic [swfd_pkg::OLEN_W-1:0]      r_olen;

    logic                             res_valid, res_matched, res_new;
    logic [SW-1:0]                    res_slot;
    logic [swfd_pkg::CHAR_W-1:0]      res_char;
    logic [LW-1:0]                    res_len;

    logic                        advance, acc, s1_go;
    logic                        char_ev, take;
    logic [swfd_pkg::PLEN_W-1:0] plen_used;
    logic [PW-1:0]               mask, mv_next, mv_shift;
    logic                        found_next;
    logic [1:0]                  track_next;
    logic [LW-1:0]               len_next;
    logic [AW-1:0]               raddr;
    logic [7:0]                  rpos_w;

    logic [swfd_pkg::CHAR_W-1:0] rd [SLOTS];
    logic [SLOTS-1:0]            cmp;
    logic [SLOTS-1:0]            eq_after;

    // Handshakes.
    assign advance     = !r_ovalid || o_out.ready;
    assign i_in.ready  = advance;
    assign acc         = i_in.valid && advance;
    assign s1_go       = r_s1_valid && advance;
    assign i_cfg.ready = 1'b1;

    // Front end: pattern matching and word tracking at acceptance.
    always_comb begin
        plen_used = (r_plen > swfd_pkg::PLEN_W'(PW)) ? swfd_pkg::PLEN_W'(PW) : r_plen;
        for (int i = 0; i < PW; i++) begin
            mask[i] = (i < int'(plen_used)) && (r_pat[i*8 +: 8] == i_in.char_in);
        end
        mv_next    = ((r_mv << 1) | PW'(1)) & mask;
        mv_shift   = mv_next >> (plen_used - swfd_pkg::PLEN_W'(1));
        found_next = r_found || ((plen_used != '0) && mv_shift[0]);
        track_next = r_track;
        if ((r_len < LW'(3)) && (r_track == r_len[1:0]) &&
            (i_in.char_in == swfd_pkg::end_char(r_len[1:0]))) begin
            track_next = r_track + 2'd1;
        end
        len_next = r_len + LW'(1);
        char_ev  = (i_in.func == swfd_pkg::FUNC_CHAR) && !n_stopped;
        take     = char_ev && (r_len < LW'(WORD_CHARS));
        rpos_w   = 8'(i_in.read_pos);
        raddr    = (i_in.func == swfd_pkg::FUNC_READ) ? rpos_w[AW-1:0] : r_len[AW-1:0];

        n_s1.func  = i_in.func;
        n_s1.ch    = i_in.char_in;
        n_s1.wend  = i_in.word_end;
        n_s1.take  = take;
        n_s1.pos   = r_len[AW-1:0];
        n_s1.len   = take ? len_next : r_len;
        n_s1.found = take ? found_next : r_found;
        n_s1.track = take ? track_next : r_track;
        n_s1.rslot = i_in.read_slot;
        n_s1.rpos  = i_in.read_pos;
        n_s1_valid = (i_in.func == swfd_pkg::FUNC_READ) ||
                     (i_in.func == swfd_pkg::FUNC_RESTART) || char_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_mv    <= '0;
            r_found <= 1'b0;
            r_track <= 2'd0;
        end else if (acc) begin
            if ((i_in.func == swfd_pkg::FUNC_RESTART) || (char_ev && i_in.word_end)) begin
                r_len   <= '0;
                r_mv    <= '0;
                r_found <= 1'b0;
                r_track <= 2'd0;
            end else if (take) begin
                r_len   <= len_next;
                r_mv    <= mv_next;
                r_found <= found_next;
                r_track <= track_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
            r_pat  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                swfd_pkg::CFG_PATTERN_LEN: r_plen <= i_cfg.data[swfd_pkg::PLEN_W-1:0];
                swfd_pkg::CFG_CHARS_A:     r_pat[63:0]    <= i_cfg.data;
                swfd_pkg::CFG_CHARS_B:     r_pat[127:64]  <= i_cfg.data;
                swfd_pkg::CFG_CHARS_C:     r_pat[191:128] <= i_cfg.data;
                swfd_pkg::CFG_CHARS_D:     r_pat[255:192] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // One word bank per slot; the next free slot takes the character tentatively.
    for (genvar s = 0; s < SLOTS; s++) begin : g_bank
        swfd_ram #(
            .WIDTH (swfd_pkg::CHAR_W),
            .DEPTH (WORD_CHARS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (acc && take && (n_count == CW'(s))),
            .i_waddr (r_len[AW-1:0]),
            .i_wdata (i_in.char_in),
            .i_re    (acc),
            .i_raddr (raddr),
            .o_rdata (rd[s])
        );
    end

    // Second stage: slot compare, table update and result.
    always_comb begin
        logic          hit;
        logic [SW-1:0] rsi;
        logic [8:0]    rpos9;
        for (int s = 0; s < SLOTS; s++) begin
            cmp[s] = (LW'(r_s1.pos) < r_slen[s]) && (rd[s] == r_s1.ch);
        end
        eq_after    = r_s1.take ? (r_eq & cmp) : r_eq;
        n_eq        = r_eq;
        n_slen      = r_slen;
        n_count     = r_count;
        n_stopped   = r_stopped;
        res_valid   = 1'b0;
        res_matched = 1'b0;
        res_new     = 1'b0;
        res_slot    = '0;
        res_char    = '0;
        res_len     = '0;
        hit         = 1'b0;
        rsi         = SW'(r_s1.rslot);
        rpos9       = 9'(r_s1.rpos);
        if (r_s1_valid) begin
            unique case (r_s1.func)
                swfd_pkg::FUNC_RESTART: begin
                    n_eq      = '1;
                    n_count   = '0;
                    n_stopped = 1'b0;
                    for (int s = 0; s < SLOTS; s++) begin
                        n_slen[s] = '0;
                    end
                end
                swfd_pkg::FUNC_READ: begin
                    res_valid = 1'b1;
                    if (7'(r_s1.rslot) < 7'(SLOTS)) begin
                        res_len = r_slen[rsi];
                        if ((rpos9 < 9'(r_slen[rsi])) && (rpos9 < 9'(WORD_CHARS))) begin
                            res_char = rd[rsi];
                        end
                    end
                end
                swfd_pkg::FUNC_CHAR: begin
                    n_eq = eq_after;
                    if (r_s1.wend) begin
                        res_valid = 1'b1;
                        n_eq      = '1;
                        if ((r_s1.len == LW'(3)) && (r_s1.track == swfd_pkg::END_LEN)) begin
                            n_stopped = 1'b1;
                        end else if (r_s1.found || (r_plen == '0)) begin
                            res_matched = 1'b1;
                            for (int s = SLOTS - 1; s >= 0; s--) begin
                                if ((CW'(s) < r_count) && eq_after[s] &&
                                    (r_slen[s] == r_s1.len)) begin
                                    hit      = 1'b1;
                                    res_slot = SW'(s);
                                end
                            end
                            if (!hit && (r_count < CW'(SLOTS))) begin
                                res_new                  = 1'b1;
                                res_slot                 = r_count[SW-1:0];
                                n_slen[r_count[SW-1:0]]  = r_s1.len;
                                n_count                  = r_count + CW'(1);
                                if (r_count + CW'(1) >= CW'(SLOTS)) begin
                                    n_stopped = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (!advance) begin
            n_eq      = r_eq;
            n_slen    = r_slen;
            n_count   = r_count;
            n_stopped = r_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_eq       <= '1;
            r_count    <= '0;
            r_stopped  <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_slen[s] <= '0;
            end
        end else begin
            if (acc) begin
                r_s1_valid <= n_s1_valid;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            r_eq      <= n_eq;
            r_slen    <= n_slen;
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (s1_go && res_valid) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && res_valid) begin
            r_omatched <= res_matched;
            r_onew     <= res_new;
            r_oslot    <= swfd_pkg::OSLOT_W'(res_slot);
            r_ocount   <= swfd_pkg::OCOUNT_W'(n_count);
            r_ostop    <= n_stopped;
            r_ochar    <= res_char;
            r_olen     <= swfd_pkg::OLEN_W'(res_len);
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.word_matched   = r_omatched;
    assign o_out.word_new       = r_onew;
    assign o_out.word_slot      = r_oslot;
    assign o_out.stored_count   = r_ocount;
    assign o_out.intake_stopped = r_ostop;
    assign o_out.read_char      = r_ochar;
    assign o_out.read_len       = r_olen;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("Table count exceeds the slot count.");

    a_full_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(SLOTS)) |-> r_stopped)
        else $error("Full table without stopped intake.");

    a_new_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && o_out.word_new) |-> o_out.word_matched)
        else $error("New word reported without a match.");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1)))
        else $error("Second stage changed during a stall.");
endmodule
